// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. All of them expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define HPF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hpf: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define HPF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpf: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define HPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpf: next-cycle check violated");

`else

`define HPF_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define HPF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define HPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/hpf_pkg.sv =====
// ----------------------------------------------------------------------------
// hpf_pkg
// Types, constants and arithmetic helpers of the half-pel six-tap filter.
// ----------------------------------------------------------------------------
package hpf_pkg;

  localparam int PIX_W       = 8;
  localparam int TAPS        = 6;
  localparam int HIST_ROWS   = 5;   // rows kept per column; also the output lag
  localparam int ROW_LAG     = 5;
  localparam int COL_LAG     = 5;
  localparam int V_TAP       = 2;   // window position of the vertical half-pel
  localparam int ROW_WIDTH_W = 12;
  localparam int ROW_CNT_W   = 3;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 12'd2048;

  // Unrounded filter sums: one pass fits 15 bits signed, two passes 21 bits.
  localparam int VSUM_W  = 15;
  localparam int CSUM_W  = 21;
  localparam int VT_W    = VSUM_W + 1;
  localparam int CT_W    = CSUM_W + 1;
  localparam int H_BIAS  = 16;
  localparam int H_SHIFT = 5;
  localparam int C_BIAS  = 512;
  localparam int C_SHIFT = 10;

  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_PTR_W = 3;
  localparam int OFIFO_CNT_W = 4;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [VSUM_W-1:0] vsum_t;
  typedef logic signed [CSUM_W-1:0] csum_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } pix_in_t;

  typedef struct packed {
    pix_t h_pel;
    pix_t v_pel;
    pix_t c_pel;
    logic row_end;
  } pel_out_t;

  // Accepted transaction as handed to the column stage.
  typedef struct packed {
    logic valid;
    pix_t pix;
    logic emit;
    logic last;
  } acc_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic     valid;
    pel_out_t data;
  } push_t;

  // Taps 1,-5,20,20,-5,1 over unsigned pixels, built from shifts and adds.
  function automatic vsum_t tap6_pix(input pix_t a, input pix_t b, input pix_t c,
                                     input pix_t d, input pix_t e, input pix_t f);
    vsum_t outer;
    vsum_t mid;
    vsum_t inner;
    outer = VSUM_W'(a) + VSUM_W'(f);
    mid   = VSUM_W'(b) + VSUM_W'(e);
    inner = VSUM_W'(c) + VSUM_W'(d);
    return (inner <<< 4) + (inner <<< 2) - (mid <<< 2) - mid + outer;
  endfunction

  function automatic pix_t clip_h(input vsum_t v);
    logic signed [VT_W-1:0] t;
    t = VT_W'(v) + VT_W'(H_BIAS);
    if (t[VT_W-1]) begin
      return '0;
    end else if (|t[VT_W-2:H_SHIFT+PIX_W]) begin
      return '1;
    end else begin
      return t[H_SHIFT+PIX_W-1:H_SHIFT];
    end
  endfunction

  function automatic pix_t clip_c(input csum_t v);
    logic signed [CT_W-1:0] t;
    t = CT_W'(v) + CT_W'(C_BIAS);
    if (t[CT_W-1]) begin
      return '0;
    end else if (|t[CT_W-2:C_SHIFT+PIX_W]) begin
      return '1;
    end else begin
      return t[C_SHIFT+PIX_W-1:C_SHIFT];
    end
  endfunction

endpackage

// ===== hw/rtl/hpf_stream_if.sv =====
// ----------------------------------------------------------------------------
// hpf_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface hpf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hpf_ram.sv =====
// ----------------------------------------------------------------------------
// hpf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpf_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/hpf_column.sv =====
// ----------------------------------------------------------------------------
// hpf_column
// Column history read-modify-write, vertical filter and the two windows.
// ----------------------------------------------------------------------------
module hpf_column #(
  parameter int MAX_ROW_WIDTH = 2048,
  localparam int AW = $clog2(MAX_ROW_WIDTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hpf_pkg::acc_t  acc,
  input  logic [AW-1:0]  acc_col,
  output hpf_pkg::tag_t  s2,
  output hpf_pkg::pix_t  pix_win  [hpf_pkg::TAPS],
  output hpf_pkg::vsum_t vsum_win [hpf_pkg::TAPS]
);
  import hpf_pkg::*;

  localparam int WORD_W = HIST_ROWS * PIX_W;

  logic              s1_valid_r;
  logic              s1_emit_r;
  logic              s1_last_r;
  pix_t              s1_pix_r;
  logic [AW-1:0]     s1_col_r;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] col_word;
  logic [WORD_W-1:0] wb_word;
  logic              wb_valid_r;
  logic [AW-1:0]     wb_col_r;
  logic [WORD_W-1:0] wb_word_r;
  vsum_t             vsum;
  pix_t              pix_win_r  [TAPS];
  vsum_t             vsum_win_r [TAPS];
  tag_t              s2_r;

  // One word per column holds the five previous rows, oldest in the low byte.
  hpf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROW_WIDTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (wb_word),
    .re    (acc.valid),
    .raddr (acc_col),
    .rdata (ram_rdata)
  );

  // The write of the previous transaction lands on the same edge as this
  // transaction's read, so a matching column takes the written word instead.
  assign col_word = (wb_valid_r && (wb_col_r == s1_col_r)) ? wb_word_r : ram_rdata;

  assign vsum = tap6_pix(col_word[0*PIX_W +: PIX_W], col_word[1*PIX_W +: PIX_W],
                         col_word[2*PIX_W +: PIX_W], col_word[3*PIX_W +: PIX_W],
                         col_word[4*PIX_W +: PIX_W], s1_pix_r);

  assign wb_word = {s1_pix_r, col_word[WORD_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
      s2_r       <= '0;
      for (int i = 0; i < TAPS; i++) begin
        pix_win_r[i]  <= '0;
        vsum_win_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= acc.valid;
      wb_valid_r <= s1_valid_r;
      s2_r.valid <= s1_valid_r && s1_emit_r;
      s2_r.last  <= s1_last_r;
      if (s1_valid_r) begin
        for (int i = 0; i < TAPS - 1; i++) begin
          pix_win_r[i]  <= pix_win_r[i+1];
          vsum_win_r[i] <= vsum_win_r[i+1];
        end
        pix_win_r[TAPS-1]  <= col_word[2*PIX_W +: PIX_W];
        vsum_win_r[TAPS-1] <= vsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc.valid) begin
      s1_pix_r  <= acc.pix;
      s1_emit_r <= acc.emit;
      s1_last_r <= acc.last;
      s1_col_r  <= acc_col;
    end
    wb_col_r  <= s1_col_r;
    wb_word_r <= wb_word;
  end

  assign s2       = s2_r;
  assign pix_win  = pix_win_r;
  assign vsum_win = vsum_win_r;
endmodule

// ===== hw/rtl/hpf_filter.sv =====
// ----------------------------------------------------------------------------
// hpf_filter
// Horizontal and centre filters over the windows, then rounding and clipping.
// ----------------------------------------------------------------------------
module hpf_filter (
  input  logic           clk,
  input  logic           rst_n,
  input  hpf_pkg::tag_t  s2,
  input  hpf_pkg::pix_t  pix_win  [hpf_pkg::TAPS],
  input  hpf_pkg::vsum_t vsum_win [hpf_pkg::TAPS],
  output hpf_pkg::push_t push
);
  import hpf_pkg::*;

  function automatic csum_t tap6_vsum(input vsum_t a, input vsum_t b, input vsum_t c,
                                      input vsum_t d, input vsum_t e, input vsum_t f);
    csum_t outer;
    csum_t mid;
    csum_t inner;
    outer = CSUM_W'(a) + CSUM_W'(f);
    mid   = CSUM_W'(b) + CSUM_W'(e);
    inner = CSUM_W'(c) + CSUM_W'(d);
    return (inner <<< 4) + (inner <<< 2) - (mid <<< 2) - mid + outer;
  endfunction

  logic     a_valid_r;
  logic     a_last_r;
  vsum_t    a_h_r;
  vsum_t    a_v_r;
  csum_t    a_c_r;
  logic     push_valid_r;
  pel_out_t push_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      push_valid_r <= 1'b0;
    end else begin
      a_valid_r    <= s2.valid;
      push_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_last_r <= s2.last;
    a_h_r    <= tap6_pix(pix_win[0], pix_win[1], pix_win[2],
                         pix_win[3], pix_win[4], pix_win[5]);
    a_v_r    <= vsum_win[V_TAP];
    a_c_r    <= tap6_vsum(vsum_win[0], vsum_win[1], vsum_win[2],
                          vsum_win[3], vsum_win[4], vsum_win[5]);

    push_data_r.h_pel   <= clip_h(a_h_r);
    push_data_r.v_pel   <= clip_h(a_v_r);
    push_data_r.c_pel   <= clip_c(a_c_r);
    push_data_r.row_end <= a_last_r;
  end

  assign push.valid = push_valid_r;
  assign push.data  = push_data_r;
endmodule

// ===== hw/rtl/hpf_ofifo.sv =====
// ----------------------------------------------------------------------------
// hpf_ofifo
// Small result queue that decouples the filter pipeline from output stalls.
// ----------------------------------------------------------------------------
module hpf_ofifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hpf_pkg::push_t                    push,
  hpf_stream_if.source                      out_if,
  output logic [hpf_pkg::OFIFO_CNT_W-1:0]   count
);
  import hpf_pkg::*;

  pel_out_t               mem_r [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wptr_r;
  logic [OFIFO_PTR_W-1:0] rptr_r;
  logic [OFIFO_CNT_W-1:0] cnt_r;
  logic [OFIFO_CNT_W-1:0] cnt_nxt;
  logic                   pop;

  assign pop     = out_if.valid && out_if.ready;
  assign cnt_nxt = cnt_r + OFIFO_CNT_W'(push.valid) - OFIFO_CNT_W'(pop);

  // The upstream credit count keeps pushes from ever meeting a full queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wptr_r <= wptr_r + OFIFO_PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + OFIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wptr_r] <= push.data;
    end
  end

  assign out_if.valid = (cnt_r != '0);
  assign out_if.data  = mem_r[rptr_r];
  assign count        = cnt_r;
endmodule

// ===== hw/rtl/luma_half_pel_six_tap_filter.sv =====
// ----------------------------------------------------------------------------
// luma_half_pel_six_tap_filter
// Half-pel interpolation (taps 1,-5,20,20,-5,1) of a padded luma region.
//
//   channel   dir  payload                          handshake
//   in_if     in   pixel, frame_start               valid/ready
//   out_if    out  h_pel, v_pel, c_pel, row_end     valid/ready
//   cfg_*     in   row_width                        write enable
//
// One pixel is taken per clock while in_if.ready is high; the column
// history RAM is read and written once per cycle, which sets that rate.
// Reset is synchronous and needs no clearing pass. Output stalls fill an
// eight-entry queue; in_if.ready drops only when the queue plus the
// transactions still in the pipeline would overflow it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module luma_half_pel_six_tap_filter #(
  parameter int MAX_ROW_WIDTH = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hpf_stream_if.sink                         in_if,
  hpf_stream_if.source                       out_if,
  input  logic                               cfg_wr_en,
  input  logic [hpf_pkg::ROW_WIDTH_W-1:0]    cfg_wr_data
);
  import hpf_pkg::*;

  localparam int AW = $clog2(MAX_ROW_WIDTH);
  localparam int CW = (AW + 1 > ROW_WIDTH_W) ? AW + 1 : ROW_WIDTH_W;

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [AW-1:0]          column_count_r;
  logic [AW-1:0]          column_count_nxt;
  logic [ROW_CNT_W-1:0]   row_count_r;
  logic [ROW_CNT_W-1:0]   row_count_nxt;
  logic [OFIFO_CNT_W-1:0] pend_r;
  logic [OFIFO_CNT_W-1:0] pend_nxt;
  logic [OFIFO_CNT_W-1:0] fifo_cnt;

  logic                   acc_fire;
  logic [AW-1:0]          cur_col;
  logic [ROW_CNT_W-1:0]   cur_row;
  logic [CW-1:0]          next_col_ext;
  logic                   acc_last;
  logic                   acc_emit;
  acc_t                   acc;
  tag_t                   s2;
  pix_t                   pix_win  [TAPS];
  vsum_t                  vsum_win [TAPS];
  push_t                  push;

  assign acc_fire = in_if.valid && in_if.ready;

  // A region start clears both counts before this pixel is placed.
  assign cur_col = in_if.data.frame_start ? '0 : column_count_r;
  assign cur_row = in_if.data.frame_start ? '0 : row_count_r;

  // The row ends when the next column reaches the width, clamped to the
  // history depth; a width of zero therefore behaves as one.
  assign next_col_ext = CW'(cur_col) + CW'(1);
  assign acc_last = (next_col_ext >= CW'(row_width_r)) ||
                    (cur_col == AW'(MAX_ROW_WIDTH - 1));
  assign acc_emit = (cur_row == ROW_CNT_W'(ROW_LAG)) && (cur_col >= AW'(COL_LAG));

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (acc_fire) begin
      if (acc_last) begin
        column_count_nxt = '0;
        row_count_nxt    = (cur_row < ROW_CNT_W'(ROW_LAG)) ? cur_row + ROW_CNT_W'(1)
                                                           : cur_row;
      end else begin
        column_count_nxt = next_col_ext[AW-1:0];
        row_count_nxt    = cur_row;
      end
    end
  end

  // Emitting transactions accepted but not yet queued hold a queue slot.
  assign pend_nxt = pend_r + OFIFO_CNT_W'(acc_fire && acc_emit) - OFIFO_CNT_W'(push.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RST;
      column_count_r <= '0;
      row_count_r    <= '0;
      pend_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        row_width_r <= cfg_wr_data;
      end
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      pend_r         <= pend_nxt;
    end
  end

  assign in_if.ready = ((OFIFO_CNT_W+1)'(pend_r) + (OFIFO_CNT_W+1)'(fifo_cnt))
                       < (OFIFO_CNT_W+1)'(OFIFO_DEPTH);

  assign acc.valid = acc_fire;
  assign acc.pix   = in_if.data.pixel;
  assign acc.emit  = acc_emit;
  assign acc.last  = acc_last;

  hpf_column #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_column (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .acc_col  (cur_col),
    .s2       (s2),
    .pix_win  (pix_win),
    .vsum_win (vsum_win)
  );

  hpf_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2       (s2),
    .pix_win  (pix_win),
    .vsum_win (vsum_win),
    .push     (push)
  );

  hpf_ofifo u_ofifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .out_if (out_if),
    .count  (fifo_cnt)
  );

  `HPF_ASSERT_ALWAYS(a_credit_bound, clk, rst_n, ((OFIFO_CNT_W+1)'(pend_r) + (OFIFO_CNT_W+1)'(fifo_cnt)) <= (OFIFO_CNT_W+1)'(OFIFO_DEPTH))
  `HPF_ASSERT_ALWAYS(a_row_saturates, clk, rst_n, row_count_r <= ROW_CNT_W'(ROW_LAG))
  `HPF_ASSERT_ALWAYS(a_col_in_range, clk, rst_n, (AW+1)'(column_count_r) < (AW+1)'(MAX_ROW_WIDTH))
  `HPF_ASSERT_NEXT(a_last_wraps_col, clk, rst_n, acc_fire && acc_last, column_count_r == '0)
  `HPF_ASSERT_IMPLIES(a_push_has_credit, clk, rst_n, push.valid, pend_r != '0)

endmodule
